>>> hw/rtl/tsdw_pkg.sv
// Package with the shared types, codes and constants of the song duration walker.
package tsdw_pkg;

    localparam int CHANNEL_SLOTS_DEF      = 16;
    localparam int FLAG_TABLE_ENTRIES_DEF = 14;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REG_TEMPO     = 2'd0;
    localparam logic [1:0] REG_SPEED     = 2'd1;
    localparam logic [1:0] REG_FLAG_LOW  = 2'd2;
    localparam logic [1:0] REG_FLAG_HIGH = 2'd3;

    localparam logic [7:0]  FX_SPEED    = 8'd1;
    localparam logic [7:0]  FX_JUMP     = 8'd2;
    localparam logic [7:0]  FX_TEMPO    = 8'd20;
    localparam logic [15:0] TEMPO_NUM   = 16'd40000;
    localparam logic [15:0] DEFAULT_SPT = 16'd300;
    localparam logic [20:0] MS_MUL      = 21'd1050000;
    localparam logic [7:0]  NOTE_CUT    = 8'hFF;
    localparam logic [7:0]  PLAY_BITS   = 8'h11;
    localparam logic [7:0]  REUSE_FX    = 8'h80;
    localparam logic [8:0]  NO_NOTE     = 9'h100;
    localparam logic [4:0]  NO_CHANNEL  = 5'd31;
    localparam logic [41:0] TOTAL_MAX   = {42{1'b1}};

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ROWS,
        PH_EVENT,
        PH_FLAG,
        PH_NOTE,
        PH_VOL,
        PH_PAN,
        PH_FXCODE,
        PH_FXPARAM,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        CT_IDLE,
        CT_STEP,
        CT_DIV,
        CT_ROW,
        CT_MUL_LO,
        CT_MUL_HI,
        CT_LOAD
    } ctl_state_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic row_add;
        logic mul_lo;
        logic mul_hi;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic row_end;
        logic emit_now;
        logic song_now;
        logic emit_pend;
        logic song_pend;
        logic div_done;
        logic div_busy;
        logic out_full;
    } dp_sts_t;

endpackage

>>> hw/rtl/tsdw_if.sv
// Channel interfaces for input items, result items and configuration writes.
interface tsdw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface tsdw_out_if;
    logic        valid;
    logic        ready;
    logic        event_res;
    logic [38:0] duration_ms;
    logic [4:0]  channel_count;
    logic        loops;
    modport source (output valid, output event_res, output duration_ms,
                    output channel_count, output loops, input ready);
    modport sink (input valid, input event_res, input duration_ms,
                  input channel_count, input loops, output ready);
endinterface

interface tsdw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [55:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/tsdw_div.sv
// Restoring divider that forms the tempo constant divided by an 8-bit value.
module tsdw_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  divisor,
    output logic        busy,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic [15:0] quo_reg, quo_next;
    logic [8:0]  trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, tsdw_pkg::TEMPO_NUM[cnt_reg]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd15;
            rem_next  = '0;
            quo_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 8'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/tsdw_datapath.sv
// Datapath with the parse state, channel memories, totals, divider and result register.
module tsdw_datapath
#(
    parameter int CHANNEL_SLOTS      = tsdw_pkg::CHANNEL_SLOTS_DEF,
    parameter int FLAG_TABLE_ENTRIES = tsdw_pkg::FLAG_TABLE_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tsdw_pkg::ctl_cmd_t  cmd,
    output tsdw_pkg::dp_sts_t   sts,
    input  logic [1:0]          command,
    input  logic [7:0]          data_byte,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [55:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                event_res,
    output logic [38:0]         duration_ms,
    output logic [4:0]          channel_count,
    output logic                loops
);

    localparam int         CH_W   = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
    localparam logic [4:0] CH_N   = 5'(CHANNEL_SLOTS);
    localparam logic [4:0] FT_N   = 5'(FLAG_TABLE_ENTRIES);

    logic [7:0]  tempo_reg, speed_cfg_reg;
    logic [55:0] ftl_reg, fth_reg;
    logic [1:0]  cmd_reg;
    logic [7:0]  byte_reg;

    tsdw_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  rows_reg, rows_next;
    logic [7:0]  flags_reg, flags_next;
    logic [4:0]  chan_reg, chan_next;
    logic [7:0]  flag_mem_reg [CHANNEL_SLOTS];
    logic [7:0]  flag_mem_next [CHANNEL_SLOTS];
    logic [7:0]  fx_mem_reg [CHANNEL_SLOTS];
    logic [7:0]  fx_mem_next [CHANNEL_SLOTS];
    logic [7:0]  par_mem_reg [CHANNEL_SLOTS];
    logic [7:0]  par_mem_next [CHANNEL_SLOTS];
    logic [8:0]  note_mem_reg [CHANNEL_SLOTS];
    logic [8:0]  note_mem_next [CHANNEL_SLOTS];
    logic [7:0]  hfx_reg, hfx_next;
    logic [7:0]  hpar_reg, hpar_next;
    logic [15:0] spt_reg, spt_next;
    logic [7:0]  speed_reg, speed_next;
    logic [7:0]  pend_reg, pend_next;
    logic        jump_reg, jump_next;
    logic [CHANNEL_SLOTS-1:0] played_reg, played_next;
    logic [41:0] total_reg, total_next;
    logic [23:0] prod_reg, prod_next;
    logic [62:0] acc_reg, acc_next;
    logic        emit_reg, emit_next;
    logic        song_reg, song_next;

    logic        ov_reg, ores_reg, oloops_reg;
    logic [38:0] odur_reg;
    logic [4:0]  ocnt_reg;

    logic        need_div, row_end, adv;
    logic [3:0]  adv_done, rest, idx;
    logic [7:0]  div_divisor, ffx, fpar;
    logic        chan_ok;
    logic [CH_W-1:0] ci;
    logic [4:0]  nib_m1, pop;
    logic        div_busy, div_done;
    logic [15:0] div_q;
    logic [42:0] sum;

    tsdw_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.step && need_div),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        rows_next     = rows_reg;
        flags_next    = flags_reg;
        chan_next     = chan_reg;
        flag_mem_next = flag_mem_reg;
        fx_mem_next   = fx_mem_reg;
        par_mem_next  = par_mem_reg;
        note_mem_next = note_mem_reg;
        hfx_next      = hfx_reg;
        hpar_next     = hpar_reg;
        spt_next      = spt_reg;
        speed_next    = speed_reg;
        pend_next     = pend_reg;
        jump_next     = jump_reg;
        played_next   = played_reg;
        prod_next     = prod_reg;
        emit_next     = 1'b0;
        song_next     = 1'b0;
        need_div      = 1'b0;
        row_end       = 1'b0;
        div_divisor   = tempo_reg;
        adv           = 1'b0;
        adv_done      = 4'd0;
        rest          = 4'd0;
        idx           = 4'd0;
        ffx           = 8'd0;
        fpar          = 8'd0;
        nib_m1        = 5'd0;
        chan_ok       = 1'b0;
        ci            = '0;
        if (cmd.step)
        begin
            if (cmd_reg == tsdw_pkg::CMD_START)
            begin
                rows_next  = 8'd0;
                flags_next = 8'd0;
                chan_next  = tsdw_pkg::NO_CHANNEL;
                for (int i = 0; i < CHANNEL_SLOTS; i++)
                begin
                    flag_mem_next[i] = 8'd0;
                    fx_mem_next[i]   = 8'd0;
                    par_mem_next[i]  = 8'd0;
                    note_mem_next[i] = tsdw_pkg::NO_NOTE;
                end
                hfx_next    = 8'd0;
                hpar_next   = 8'd0;
                spt_next    = tsdw_pkg::DEFAULT_SPT;
                need_div    = (tempo_reg != 8'd0);
                speed_next  = speed_cfg_reg;
                pend_next   = 8'd0;
                jump_next   = 1'b0;
                played_next = '0;
                phase_next  = tsdw_pkg::PH_ROWS;
            end
            else if (cmd_reg == tsdw_pkg::CMD_NOP || phase_reg == tsdw_pkg::PH_IDLE ||
                     phase_reg == tsdw_pkg::PH_DONE)
            begin
                phase_next = phase_reg;
            end
            else if (cmd_reg == tsdw_pkg::CMD_END)
            begin
                emit_next  = 1'b1;
                song_next  = 1'b1;
                phase_next = tsdw_pkg::PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    tsdw_pkg::PH_ROWS:
                    begin
                        if (byte_reg == 8'd0)
                        begin
                            emit_next = 1'b1;
                        end
                        else
                        begin
                            rows_next  = byte_reg;
                            phase_next = tsdw_pkg::PH_EVENT;
                        end
                    end
                    tsdw_pkg::PH_EVENT:
                    begin
                        if (byte_reg == 8'd0)
                        begin
                            row_end   = 1'b1;
                            prod_next = 24'(spt_reg) * 24'(speed_reg);
                            rows_next = rows_reg - 8'd1;
                            if (pend_reg != 8'd0)
                            begin
                                speed_next = pend_reg;
                                pend_next  = 8'd0;
                            end
                            if (jump_reg)
                            begin
                                emit_next  = 1'b1;
                                song_next  = 1'b1;
                                phase_next = tsdw_pkg::PH_DONE;
                            end
                            else if (rows_next == 8'd0)
                            begin
                                emit_next  = 1'b1;
                                phase_next = tsdw_pkg::PH_ROWS;
                            end
                        end
                        else
                        begin
                            nib_m1 = {1'b0, byte_reg[3:0]} - 5'd1;
                            if (byte_reg[3:0] == 4'd0 || nib_m1 >= CH_N)
                            begin
                                chan_next = tsdw_pkg::NO_CHANNEL;
                            end
                            else
                            begin
                                chan_next = nib_m1;
                            end
                            chan_ok = (chan_next < CH_N);
                            ci      = chan_next[CH_W-1:0];
                            if (byte_reg[7:4] == 4'd0)
                            begin
                                phase_next = tsdw_pkg::PH_FLAG;
                            end
                            else if (byte_reg[7:4] == 4'd1)
                            begin
                                flags_next = chan_ok ? flag_mem_reg[ci] : 8'd0;
                                adv        = 1'b1;
                            end
                            else
                            begin
                                idx = byte_reg[7:4] - 4'd2;
                                if ({1'b0, idx} >= FT_N)
                                begin
                                    flags_next = 8'd0;
                                end
                                else if (idx < 4'd7)
                                begin
                                    flags_next = 8'(ftl_reg >> {idx[2:0], 3'b000});
                                end
                                else
                                begin
                                    flags_next = 8'(fth_reg >> {3'(idx - 4'd7), 3'b000});
                                end
                                adv = 1'b1;
                            end
                        end
                    end
                    tsdw_pkg::PH_FLAG:
                    begin
                        flags_next = byte_reg;
                        if (chan_reg < CH_N)
                        begin
                            flag_mem_next[chan_reg[CH_W-1:0]] = byte_reg;
                        end
                        adv = 1'b1;
                    end
                    tsdw_pkg::PH_NOTE:
                    begin
                        if (chan_reg < CH_N)
                        begin
                            note_mem_next[chan_reg[CH_W-1:0]] = {1'b0, byte_reg};
                        end
                        adv      = 1'b1;
                        adv_done = 4'h1;
                    end
                    tsdw_pkg::PH_VOL:
                    begin
                        adv      = 1'b1;
                        adv_done = 4'h3;
                    end
                    tsdw_pkg::PH_PAN:
                    begin
                        adv      = 1'b1;
                        adv_done = 4'h7;
                    end
                    tsdw_pkg::PH_FXCODE:
                    begin
                        hfx_next   = byte_reg;
                        phase_next = tsdw_pkg::PH_FXPARAM;
                    end
                    tsdw_pkg::PH_FXPARAM:
                    begin
                        hpar_next = byte_reg;
                        adv       = 1'b1;
                        adv_done  = 4'hF;
                    end
                    default:
                    begin
                        phase_next = tsdw_pkg::PH_IDLE;
                    end
                endcase
            end
            if (adv)
            begin
                rest    = flags_next[3:0] & ~adv_done;
                chan_ok = (chan_next < CH_N);
                ci      = chan_next[CH_W-1:0];
                if (rest[0])
                begin
                    phase_next = tsdw_pkg::PH_NOTE;
                end
                else if (rest[1])
                begin
                    phase_next = tsdw_pkg::PH_VOL;
                end
                else if (rest[2])
                begin
                    phase_next = tsdw_pkg::PH_PAN;
                end
                else if (rest[3])
                begin
                    phase_next = tsdw_pkg::PH_FXCODE;
                end
                else
                begin
                    if (flags_next[3])
                    begin
                        ffx  = hfx_next;
                        fpar = hpar_next;
                        if (chan_ok)
                        begin
                            fx_mem_next[ci]  = hfx_next;
                            par_mem_next[ci] = hpar_next;
                        end
                    end
                    else if ((flags_next & tsdw_pkg::REUSE_FX) != 8'd0 && chan_ok)
                    begin
                        ffx  = fx_mem_reg[ci];
                        fpar = par_mem_reg[ci];
                    end
                    if (ffx == tsdw_pkg::FX_TEMPO && fpar != 8'd0)
                    begin
                        need_div    = 1'b1;
                        div_divisor = fpar;
                    end
                    else if (ffx == tsdw_pkg::FX_SPEED && fpar != 8'd0)
                    begin
                        pend_next = fpar;
                    end
                    else if (ffx == tsdw_pkg::FX_JUMP)
                    begin
                        jump_next = 1'b1;
                    end
                    if ((flags_next & tsdw_pkg::PLAY_BITS) != 8'd0 && chan_ok)
                    begin
                        if (!note_mem_next[ci][8] && note_mem_next[ci][7:0] != tsdw_pkg::NOTE_CUT)
                        begin
                            played_next[ci] = 1'b1;
                        end
                    end
                    phase_next = tsdw_pkg::PH_EVENT;
                end
            end
        end
        if (div_done)
        begin
            spt_next = div_q;
        end
    end

    always_comb
    begin
        pop = 5'd0;
        for (int i = 0; i < CHANNEL_SLOTS; i++)
        begin
            pop = pop + 5'(played_reg[i]);
        end
    end

    assign sum = {1'b0, total_reg} + {19'd0, prod_reg};

    always_comb
    begin
        total_next = total_reg;
        acc_next   = acc_reg;
        if (cmd.step && cmd_reg == tsdw_pkg::CMD_START)
        begin
            total_next = '0;
        end
        else if (cmd.row_add)
        begin
            total_next = sum[42] ? tsdw_pkg::TOTAL_MAX : sum[41:0];
        end
        if (cmd.mul_lo)
        begin
            acc_next = 63'(42'(total_reg[20:0]) * 42'(tsdw_pkg::MS_MUL));
        end
        else if (cmd.mul_hi)
        begin
            acc_next = acc_reg + (63'(42'(total_reg[41:21]) * 42'(tsdw_pkg::MS_MUL)) << 21);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg     <= 8'd0;
            speed_cfg_reg <= 8'd1;
            ftl_reg       <= '0;
            fth_reg       <= '0;
            phase_reg     <= tsdw_pkg::PH_IDLE;
            rows_reg      <= '0;
            flags_reg     <= '0;
            chan_reg      <= tsdw_pkg::NO_CHANNEL;
            for (int i = 0; i < CHANNEL_SLOTS; i++)
            begin
                flag_mem_reg[i] <= '0;
                fx_mem_reg[i]   <= '0;
                par_mem_reg[i]  <= '0;
                note_mem_reg[i] <= tsdw_pkg::NO_NOTE;
            end
            hfx_reg    <= '0;
            hpar_reg   <= '0;
            spt_reg    <= tsdw_pkg::DEFAULT_SPT;
            speed_reg  <= '0;
            pend_reg   <= '0;
            jump_reg   <= 1'b0;
            played_reg <= '0;
            total_reg  <= '0;
            emit_reg   <= 1'b0;
            song_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    tsdw_pkg::REG_TEMPO:     tempo_reg     <= cfg_data[7:0];
                    tsdw_pkg::REG_SPEED:     speed_cfg_reg <= cfg_data[7:0];
                    tsdw_pkg::REG_FLAG_LOW:  ftl_reg       <= cfg_data;
                    tsdw_pkg::REG_FLAG_HIGH: fth_reg       <= cfg_data;
                    default:                 tempo_reg     <= tempo_reg;
                endcase
            end
            phase_reg     <= phase_next;
            rows_reg      <= rows_next;
            flags_reg     <= flags_next;
            chan_reg      <= chan_next;
            flag_mem_reg  <= flag_mem_next;
            fx_mem_reg    <= fx_mem_next;
            par_mem_reg   <= par_mem_next;
            note_mem_reg  <= note_mem_next;
            hfx_reg       <= hfx_next;
            hpar_reg      <= hpar_next;
            spt_reg       <= spt_next;
            speed_reg     <= speed_next;
            pend_reg      <= pend_next;
            jump_reg      <= jump_next;
            played_reg    <= played_next;
            total_reg     <= total_next;
            if (cmd.step)
            begin
                emit_reg <= emit_next;
                song_reg <= song_next;
            end
            if (cmd.load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg  <= command;
            byte_reg <= data_byte;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.load_out)
        begin
            ores_reg   <= song_reg;
            odur_reg   <= song_reg ? acc_reg[62:24] : 39'd0;
            ocnt_reg   <= song_reg ? pop : 5'd0;
            oloops_reg <= song_reg ? jump_reg : 1'b0;
        end
    end

    assign sts.need_div  = need_div;
    assign sts.row_end   = row_end;
    assign sts.emit_now  = emit_next;
    assign sts.song_now  = song_next;
    assign sts.emit_pend = emit_reg;
    assign sts.song_pend = song_reg;
    assign sts.div_done  = div_done;
    assign sts.div_busy  = div_busy;
    assign sts.out_full  = ov_reg;

    assign out_valid     = ov_reg;
    assign event_res     = ores_reg;
    assign duration_ms   = odur_reg;
    assign channel_count = ocnt_reg;
    assign loops         = oloops_reg;

endmodule

>>> hw/rtl/tsdw_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module tsdw_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsdw_pkg::dp_sts_t  sts,
    output tsdw_pkg::ctl_cmd_t cmd
);

    tsdw_pkg::ctl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsdw_pkg::CT_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tsdw_pkg::CT_STEP;
                end
            end
            tsdw_pkg::CT_STEP:
            begin
                if (sts.need_div)
                begin
                    state_next = tsdw_pkg::CT_DIV;
                end
                else if (sts.row_end)
                begin
                    state_next = tsdw_pkg::CT_ROW;
                end
                else if (sts.song_now)
                begin
                    state_next = tsdw_pkg::CT_MUL_LO;
                end
                else if (sts.emit_now)
                begin
                    state_next = tsdw_pkg::CT_LOAD;
                end
                else
                begin
                    state_next = tsdw_pkg::CT_IDLE;
                end
            end
            tsdw_pkg::CT_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = tsdw_pkg::CT_IDLE;
                end
            end
            tsdw_pkg::CT_ROW:
            begin
                if (sts.song_pend)
                begin
                    state_next = tsdw_pkg::CT_MUL_LO;
                end
                else if (sts.emit_pend)
                begin
                    state_next = tsdw_pkg::CT_LOAD;
                end
                else
                begin
                    state_next = tsdw_pkg::CT_IDLE;
                end
            end
            tsdw_pkg::CT_MUL_LO: state_next = tsdw_pkg::CT_MUL_HI;
            tsdw_pkg::CT_MUL_HI: state_next = tsdw_pkg::CT_LOAD;
            tsdw_pkg::CT_LOAD:
            begin
                if (!sts.out_full)
                begin
                    state_next = tsdw_pkg::CT_IDLE;
                end
            end
            default: state_next = tsdw_pkg::CT_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == tsdw_pkg::CT_IDLE);
        cmd.load_in  = in_ready && in_valid;
        cmd.step     = (state_reg == tsdw_pkg::CT_STEP);
        cmd.row_add  = (state_reg == tsdw_pkg::CT_ROW);
        cmd.mul_lo   = (state_reg == tsdw_pkg::CT_MUL_LO);
        cmd.mul_hi   = (state_reg == tsdw_pkg::CT_MUL_HI);
        cmd.load_out = (state_reg == tsdw_pkg::CT_LOAD) && !sts.out_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsdw_pkg::CT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/tracker_song_duration_walker.sv
// Top level of the tracker song duration walker.
//
//  Channel   Dir  Handshake     Payload
//  in_ch     in   valid/ready   command, data_byte
//  out_ch    out  valid/ready   event_res, duration_ms, channel_count, loops
//  cfg_ch    in   valid/ready   index, data (always ready)
//
// A pattern byte is accepted in CT_IDLE and applied in CT_STEP.
// A row end adds the CT_ROW state for the saturating total update.
// A tempo change or a song start with a nonzero tempo adds a wait in CT_DIV for the serial divider.
// A song finish adds the CT_MUL_LO and CT_MUL_HI states for the millisecond product, split into two 21-bit halves.
// A result enters the output register from CT_LOAD, which waits while an older one is still there.
// Reset clears all control state and the channel memories at once.
module tracker_song_duration_walker
#(
    parameter int CHANNEL_SLOTS      = tsdw_pkg::CHANNEL_SLOTS_DEF,
    parameter int FLAG_TABLE_ENTRIES = tsdw_pkg::FLAG_TABLE_ENTRIES_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    tsdw_in_if.sink     in_ch,
    tsdw_out_if.source  out_ch,
    tsdw_cfg_if.sink    cfg_ch
);

    tsdw_pkg::ctl_cmd_t cmd;
    tsdw_pkg::dp_sts_t  sts;

    assign cfg_ch.ready = 1'b1;

    tsdw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsdw_datapath
    #(
        .CHANNEL_SLOTS      (CHANNEL_SLOTS),
        .FLAG_TABLE_ENTRIES (FLAG_TABLE_ENTRIES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .command       (in_ch.command),
        .data_byte     (in_ch.data_byte),
        .cfg_write     (cfg_ch.valid),
        .cfg_index     (cfg_ch.index),
        .cfg_data      (cfg_ch.data),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .event_res     (out_ch.event_res),
        .duration_ms   (out_ch.duration_ms),
        .channel_count (out_ch.channel_count),
        .loops         (out_ch.loops)
    );

`ifndef SYNTH
    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_hi |-> $past(cmd.mul_lo))
        else $error("high product half without low half");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_full)
        else $error("result loaded over a waiting result");
    a_no_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !sts.div_busy)
        else $error("item accepted while divider busy");
    a_pattern_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.event_res) |-> (out_ch.duration_ms == '0 && !out_ch.loops))
        else $error("pattern result carries totals");
`endif

endmodule
